/* hw/rtl/mmfr_pkg.sv */
package mmfr_pkg;

  localparam int ROUTE_SLOTS = 16;
  localparam int SLOT_IW     = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(ROUTE_SLOTS + 1);
  localparam int HANDLE_W    = 31;
  localparam int SLOT_OUT_W  = 4;
  localparam int DCNT_OUT_W  = 5;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_ROUTE  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_MATCH  = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0]         mask;
    logic [31:0]         match;
    logic [HANDLE_W-1:0] handle;
  } route_rec_t;

endpackage

/* hw/rtl/mmfr_route_mem.sv */
module mmfr_route_mem
  import mmfr_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [SLOT_IW-1:0] wr_addr,
  input  route_rec_t         wr_data,
  input  logic               rd_en,
  input  logic [SLOT_IW-1:0] rd_addr,
  output route_rec_t         rd_data
);

  route_rec_t mem [ROUTE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/masked_match_fanout_router.sv */
// Masked-match routing table with ROUTE_SLOTS slots held in a single-port-read
// memory. Each request is handled alone: an add, remove or route request walks
// the slots one per cycle through the memory read port (add stops at the
// first free slot, remove at the matching handle; an add refused as table full
// or handles exhausted skips the walk). A route request yields one result per
// matching slot in slot order with a running delivery count, tlast on the
// final one, or a single no-match result. in_tready is high only between
// requests; a backpressured output stalls the walk. Function code 3 is dropped.
module masked_match_fanout_router
  import mmfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] route_mask, [63:32] route_match, [94:64] remove_handle,
  // [126:95] signal_ident, [127] zero
  input  logic [127:0] in_tdata,
  // [1:0] func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [30:0] route_handle, [34:31] route_slot, [39:35] delivered_count
  output logic [39:0]  out_tdata,
  // [2:0] status
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam logic [SLOT_IW-1:0] LAST_IDX  = SLOT_IW'(ROUTE_SLOTS - 1);
  localparam logic [CNT_W-1:0]   SLOTS_CNT = CNT_W'(ROUTE_SLOTS);

  state_t                  state_r, state_nxt;
  logic [ROUTE_SLOTS-1:0]  slot_valid_r, slot_valid_nxt;
  logic [31:0]             next_handle_r, next_handle_nxt;
  logic [CNT_W-1:0]        active_r, active_nxt;

  func_t                   func_r, func_nxt;
  logic [31:0]             mask_r, mask_nxt;
  logic [31:0]             match_r, match_nxt;
  logic [HANDLE_W-1:0]     rhandle_r, rhandle_nxt;
  logic [31:0]             sig_r, sig_nxt;

  logic [SLOT_IW-1:0]      scan_idx_r, scan_idx_nxt;
  logic                    issue_done_r, issue_done_nxt;
  logic                    rdv_r, rdv_nxt;
  logic [SLOT_IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic                    vq_r, vq_nxt;
  logic [CNT_W-1:0]        hit_cnt_r, hit_cnt_nxt;

  logic                    pend_vld_r, pend_vld_nxt;
  logic [HANDLE_W-1:0]     pend_handle_r, pend_handle_nxt;
  logic [SLOT_IW-1:0]      pend_slot_r, pend_slot_nxt;
  logic [CNT_W-1:0]        pend_cnt_r, pend_cnt_nxt;

  status_t                 fin_status_r, fin_status_nxt;
  logic [HANDLE_W-1:0]     fin_handle_r, fin_handle_nxt;
  logic [SLOT_OUT_W-1:0]   fin_slot_r, fin_slot_nxt;
  logic [DCNT_OUT_W-1:0]   fin_cnt_r, fin_cnt_nxt;

  logic                    out_tvalid_r, out_tvalid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0]     out_handle_r, out_handle_nxt;
  logic [SLOT_OUT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [DCNT_OUT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    out_free;
  logic                    mem_we;
  route_rec_t              mem_wdata;
  logic                    mem_re;
  route_rec_t              mem_rdata;
  logic                    hit;
  logic                    stall;
  logic                    last_slot;

  mmfr_route_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (rd_idx_r),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (scan_idx_r),
    .rd_data (mem_rdata)
  );

  assign out_free  = !out_tvalid_r || out_tready;
  assign last_slot = (rd_idx_r == LAST_IDX);
  assign mem_wdata = '{mask: mask_r, match: match_r, handle: next_handle_r[HANDLE_W-1:0]};

  always_comb begin
    case (func_r)
      FN_ADD:    hit = !vq_r;
      FN_REMOVE: hit = vq_r && (mem_rdata.handle == rhandle_r);
      FN_ROUTE:  hit = vq_r && ((sig_r & mem_rdata.mask) == mem_rdata.match);
      default:   hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    slot_valid_nxt  = slot_valid_r;
    next_handle_nxt = next_handle_r;
    active_nxt      = active_r;
    func_nxt        = func_r;
    mask_nxt        = mask_r;
    match_nxt       = match_r;
    rhandle_nxt     = rhandle_r;
    sig_nxt         = sig_r;
    scan_idx_nxt    = scan_idx_r;
    issue_done_nxt  = issue_done_r;
    rdv_nxt         = rdv_r;
    rd_idx_nxt      = rd_idx_r;
    vq_nxt          = vq_r;
    hit_cnt_nxt     = hit_cnt_r;
    pend_vld_nxt    = pend_vld_r;
    pend_handle_nxt = pend_handle_r;
    pend_slot_nxt   = pend_slot_r;
    pend_cnt_nxt    = pend_cnt_r;
    fin_status_nxt  = fin_status_r;
    fin_handle_nxt  = fin_handle_r;
    fin_slot_nxt    = fin_slot_r;
    fin_cnt_nxt     = fin_cnt_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_handle_nxt  = out_handle_r;
    out_slot_nxt    = out_slot_r;
    out_cnt_nxt     = out_cnt_r;
    out_last_nxt    = out_last_r;
    in_tready       = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    stall           = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt       = func_t'(in_tuser);
          mask_nxt       = in_tdata[31:0];
          match_nxt      = in_tdata[63:32];
          rhandle_nxt    = in_tdata[94:64];
          sig_nxt        = in_tdata[126:95];
          scan_idx_nxt   = '0;
          issue_done_nxt = 1'b0;
          rdv_nxt        = 1'b0;
          hit_cnt_nxt    = '0;
          pend_vld_nxt   = 1'b0;
          fin_handle_nxt = '0;
          fin_slot_nxt   = '0;
          fin_cnt_nxt    = '0;
          case (func_t'(in_tuser))
            FN_ADD: begin
              if (active_r >= SLOTS_CNT) begin
                fin_status_nxt = ST_FULL;
                state_nxt      = S_FINISH;
              end else if (next_handle_r[31]) begin
                fin_status_nxt = ST_EXHAUSTED;
                state_nxt      = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FN_REMOVE, FN_ROUTE: state_nxt = S_SCAN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        if (rdv_r) begin
          case (func_r)
            FN_ADD: begin
              if (hit) begin
                mem_we                   = 1'b1;
                slot_valid_nxt[rd_idx_r] = 1'b1;
                next_handle_nxt          = next_handle_r + 32'd1;
                active_nxt               = active_r + CNT_W'(1);
                fin_status_nxt           = ST_OK;
                fin_handle_nxt           = next_handle_r[HANDLE_W-1:0];
                fin_slot_nxt             = SLOT_OUT_W'(rd_idx_r);
                state_nxt                = S_FINISH;
              end else if (last_slot) begin
                fin_status_nxt = ST_FULL;
                state_nxt      = S_FINISH;
              end
            end
            FN_REMOVE: begin
              fin_handle_nxt = rhandle_r;
              if (hit) begin
                slot_valid_nxt[rd_idx_r] = 1'b0;
                if (active_r != '0) begin
                  active_nxt = active_r - CNT_W'(1);
                end
                fin_status_nxt = ST_OK;
                fin_slot_nxt   = SLOT_OUT_W'(rd_idx_r);
                state_nxt      = S_FINISH;
              end else if (last_slot) begin
                fin_status_nxt = ST_NOT_FOUND;
                state_nxt      = S_FINISH;
              end
            end
            default: begin
              if (hit && pend_vld_r && !out_free) begin
                stall = 1'b1;
              end else begin
                if (hit) begin
                  if (pend_vld_r) begin
                    out_tvalid_nxt = 1'b1;
                    out_status_nxt = ST_OK;
                    out_handle_nxt = pend_handle_r;
                    out_slot_nxt   = SLOT_OUT_W'(pend_slot_r);
                    out_cnt_nxt    = DCNT_OUT_W'(pend_cnt_r);
                    out_last_nxt   = 1'b0;
                  end
                  pend_vld_nxt    = 1'b1;
                  pend_handle_nxt = mem_rdata.handle;
                  pend_slot_nxt   = rd_idx_r;
                  pend_cnt_nxt    = hit_cnt_r + CNT_W'(1);
                  hit_cnt_nxt     = hit_cnt_r + CNT_W'(1);
                end
                if (last_slot) begin
                  state_nxt = S_FINISH;
                  if (hit) begin
                    fin_status_nxt = ST_OK;
                    fin_handle_nxt = mem_rdata.handle;
                    fin_slot_nxt   = SLOT_OUT_W'(rd_idx_r);
                    fin_cnt_nxt    = DCNT_OUT_W'(hit_cnt_r + CNT_W'(1));
                  end else if (pend_vld_r) begin
                    fin_status_nxt = ST_OK;
                    fin_handle_nxt = pend_handle_r;
                    fin_slot_nxt   = SLOT_OUT_W'(pend_slot_r);
                    fin_cnt_nxt    = DCNT_OUT_W'(pend_cnt_r);
                  end else begin
                    fin_status_nxt = ST_NO_MATCH;
                  end
                end
              end
            end
          endcase
        end
        if (!stall) begin
          if (!issue_done_r) begin
            mem_re     = 1'b1;
            rdv_nxt    = 1'b1;
            rd_idx_nxt = scan_idx_r;
            vq_nxt     = slot_valid_r[scan_idx_r];
            if (scan_idx_r == LAST_IDX) begin
              issue_done_nxt = 1'b1;
            end else begin
              scan_idx_nxt = scan_idx_r + SLOT_IW'(1);
            end
          end else begin
            rdv_nxt = 1'b0;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = fin_status_r;
          out_handle_nxt = fin_handle_r;
          out_slot_nxt   = fin_slot_r;
          out_cnt_nxt    = fin_cnt_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_valid_r  <= '0;
      next_handle_r <= '0;
      active_r      <= '0;
      rdv_r         <= 1'b0;
      issue_done_r  <= 1'b0;
      pend_vld_r    <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      slot_valid_r  <= slot_valid_nxt;
      next_handle_r <= next_handle_nxt;
      active_r      <= active_nxt;
      rdv_r         <= rdv_nxt;
      issue_done_r  <= issue_done_nxt;
      pend_vld_r    <= pend_vld_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    mask_r        <= mask_nxt;
    match_r       <= match_nxt;
    rhandle_r     <= rhandle_nxt;
    sig_r         <= sig_nxt;
    scan_idx_r    <= scan_idx_nxt;
    rd_idx_r      <= rd_idx_nxt;
    vq_r          <= vq_nxt;
    hit_cnt_r     <= hit_cnt_nxt;
    pend_handle_r <= pend_handle_nxt;
    pend_slot_r   <= pend_slot_nxt;
    pend_cnt_r    <= pend_cnt_nxt;
    fin_status_r  <= fin_status_nxt;
    fin_handle_r  <= fin_handle_nxt;
    fin_slot_r    <= fin_slot_nxt;
    fin_cnt_r     <= fin_cnt_nxt;
    out_status_r  <= out_status_nxt;
    out_handle_r  <= out_handle_nxt;
    out_slot_r    <= out_slot_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_cnt_r, out_slot_r, out_handle_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // occupancy counter tracks the valid bits
  a_active_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == CNT_W'($countones(slot_valid_r)))
    else $error("active count out of step with slot valid bits");

  // only deliveries may be non-final
  a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_status_r == ST_OK && out_cnt_r != '0)
    else $error("non-final result is not a delivery");

  // no input taken while a request is in flight
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE && !stall)
    else $error("ready raised during a request");

endmodule
